/* hw/rtl/round_robin_ready_queue_macros.svh */
// ----------------------------------------------------------------------------
// Round-robin ready queue assertion macros
// Clocked implication checks shared by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_READY_QUEUE_MACROS_SVH
`define ROUND_ROBIN_READY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RRQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rrq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_pkg
// Shared types, codes and defaults for the round-robin ready queue.
// ----------------------------------------------------------------------------
package rrq_pkg;

    // field widths of the request and response words
    localparam int REQ_W = 2;
    localparam int ID_W  = 6;
    localparam int ST_W  = 3;

    // parameter defaults
    localparam int MAX_PROCS_DEF  = 64;
    localparam int NUM_QUEUES_DEF = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_OTHER    = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             queue_sel;
        logic [ID_W-1:0]  proc_id;
    } t_req_word;

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [ID_W-1:0] out_id;
    } t_rsp_word;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_TAG_RD,
        S_TAG_CHK,
        S_INS_LINK,
        S_HEAD_RM,
        S_WALK,
        S_UNLINK,
        S_POP_RD,
        S_POP_WR,
        S_DONE
    } t_state;

endpackage

/* hw/rtl/round_robin_ready_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_ready_queue
// Linked-list FIFO queues of process ids for round-robin dispatch.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_stall / i_in) carries one word: insert
//   an id at a queue tail, remove an id from anywhere in a queue, or pop the
//   head of a queue. Response channel (o_out_valid / i_out_stall / o_out)
//   returns exactly one word per request: status and, for a good pop, the id.
//   A word moves on a clock edge where valid is high and stall is low.
//   One request is in flight at a time; o_in_stall is high while it runs.
//   An empty pop or an unused code goes straight to the final state. Inserts
//   and removes read the id's tag first; a remove of an id not at the head
//   then walks the list from the head to find its predecessor. The remove walk
//   is bound by the single read port of the link RAM, one link per cycle.
//   The sequencer goes idle on the edge that raises response valid, so
//   a new request is accepted only after the last one's response is loaded.
//   A finished response sits in an output register; the next request is
//   accepted while it waits. If the receiver stalls and a second response
//   is ready, the sequencer holds in its final state until the register
//   frees up.
//   Reset (synchronous, active low) empties every queue and clears all
//   membership at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "round_robin_ready_queue_macros.svh"

module round_robin_ready_queue #(
    parameter int MAX_PROCS  = rrq_pkg::MAX_PROCS_DEF,
    parameter int NUM_QUEUES = rrq_pkg::NUM_QUEUES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  rrq_pkg::t_req_word i_in,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output rrq_pkg::t_rsp_word o_out,
    input  logic              i_out_stall
);

    localparam int ID_W  = rrq_pkg::ID_W;
    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW    = $clog2(MAX_PROCS + 1);
    localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int TAG_W = $clog2(NUM_QUEUES + 1);

    rrq_pkg::t_state r_state, n_state;

    // request context
    logic [rrq_pkg::REQ_W-1:0] r_req, n_req;
    logic [QW-1:0]             r_q, n_q;
    logic [ID_W-1:0]           r_id, n_id;
    logic [ID_W-1:0]           r_pre, n_pre;
    logic [IDX_W-1:0]          r_steps, n_steps;
    logic [rrq_pkg::ST_W-1:0]  r_status, n_status;
    logic [ID_W-1:0]           r_pop_id, n_pop_id;

    // queue descriptors
    logic [ID_W-1:0] r_head  [NUM_QUEUES];
    logic [ID_W-1:0] n_head  [NUM_QUEUES];
    logic [ID_W-1:0] r_tail  [NUM_QUEUES];
    logic [ID_W-1:0] n_tail  [NUM_QUEUES];
    logic [CW-1:0]   r_count [NUM_QUEUES];
    logic [CW-1:0]   n_count [NUM_QUEUES];

    // membership valid bits, tag reads as zero when clear
    logic [MAX_PROCS-1:0] r_tag_vld, n_tag_vld;

    // output register
    logic               r_out_valid, n_out_valid;
    rrq_pkg::t_rsp_word r_out, n_out;

    // RAM ports
    logic             lk_we;
    logic [IDX_W-1:0] lk_waddr;
    logic [ID_W-1:0]  lk_wdata;
    logic [IDX_W-1:0] lk_raddr;
    logic [ID_W-1:0]  lk_rdata;
    logic             tg_we;
    logic [IDX_W-1:0] tg_waddr;
    logic [TAG_W-1:0] tg_wdata;
    logic [IDX_W-1:0] tg_raddr;
    logic [TAG_W-1:0] tg_rdata;

    // decode helpers
    logic             in_acc;
    logic [QW-1:0]    in_q;
    logic             in_id_ok;
    logic [TAG_W-1:0] q_tag;
    logic [TAG_W-1:0] tag_cur;
    logic [IDX_W-1:0] id_idx;

    // link table and membership tag table
    rrq_ram #(.WIDTH(ID_W), .DEPTH(MAX_PROCS)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    rrq_ram #(.WIDTH(TAG_W), .DEPTH(MAX_PROCS)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tg_we),
        .i_waddr (tg_waddr),
        .i_wdata (tg_wdata),
        .i_raddr (tg_raddr),
        .o_rdata (tg_rdata)
    );

    // request decode
    always_comb begin
        in_acc   = i_in_valid && (r_state == rrq_pkg::S_IDLE);
        in_id_ok = (int'(i_in.proc_id) < MAX_PROCS);
        if (int'(i_in.queue_sel) >= NUM_QUEUES) begin
            in_q = QW'(NUM_QUEUES - 1);
        end else begin
            in_q = QW'(i_in.queue_sel);
        end
        id_idx  = IDX_W'(r_id);
        q_tag   = TAG_W'(r_q) + TAG_W'(1);
        tag_cur = r_tag_vld[id_idx] ? tg_rdata : '0;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrq_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.req_type) inside
                        rrq_pkg::REQ_INSERT, rrq_pkg::REQ_REMOVE: begin
                            n_state = in_id_ok ? rrq_pkg::S_TAG_RD : rrq_pkg::S_DONE;
                        end
                        rrq_pkg::REQ_POP: begin
                            n_state = (r_count[in_q] == '0) ? rrq_pkg::S_DONE
                                                            : rrq_pkg::S_POP_RD;
                        end
                        default: n_state = rrq_pkg::S_DONE;
                    endcase
                end
            end
            rrq_pkg::S_TAG_RD: n_state = rrq_pkg::S_TAG_CHK;
            rrq_pkg::S_TAG_CHK: begin
                if (r_req == rrq_pkg::REQ_INSERT) begin
                    if (tag_cur != '0 || r_count[r_q] == '0) begin
                        n_state = rrq_pkg::S_DONE;
                    end else begin
                        n_state = rrq_pkg::S_INS_LINK;
                    end
                end else if (tag_cur != q_tag || r_count[r_q] == '0) begin
                    n_state = rrq_pkg::S_DONE;
                end else if (r_head[r_q] == r_id) begin
                    n_state = rrq_pkg::S_HEAD_RM;
                end else begin
                    n_state = rrq_pkg::S_WALK;
                end
            end
            rrq_pkg::S_INS_LINK: n_state = rrq_pkg::S_DONE;
            rrq_pkg::S_HEAD_RM:  n_state = rrq_pkg::S_DONE;
            rrq_pkg::S_WALK: begin
                if (lk_rdata == r_id) begin
                    n_state = rrq_pkg::S_UNLINK;
                end else if (r_steps == IDX_W'(MAX_PROCS - 1)) begin
                    n_state = rrq_pkg::S_DONE;
                end
            end
            rrq_pkg::S_UNLINK:  n_state = rrq_pkg::S_DONE;
            rrq_pkg::S_POP_RD:  n_state = rrq_pkg::S_POP_WR;
            rrq_pkg::S_POP_WR:  n_state = rrq_pkg::S_DONE;
            rrq_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = rrq_pkg::S_IDLE;
                end
            end
            default: n_state = rrq_pkg::S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_req       = r_req;
        n_q         = r_q;
        n_id        = r_id;
        n_pre       = r_pre;
        n_steps     = r_steps;
        n_status    = r_status;
        n_pop_id    = r_pop_id;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_tag_vld   = r_tag_vld;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        lk_we       = 1'b0;
        lk_waddr    = id_idx;
        lk_wdata    = '0;
        lk_raddr    = id_idx;
        tg_we       = 1'b0;
        tg_waddr    = id_idx;
        tg_wdata    = q_tag;
        tg_raddr    = id_idx;

        unique case (r_state)
            rrq_pkg::S_IDLE: begin
                // latch the request and settle the trivial answers
                if (in_acc) begin
                    n_req    = i_in.req_type;
                    n_q      = in_q;
                    n_id     = i_in.proc_id;
                    n_pop_id = '0;
                    n_status = rrq_pkg::ST_OK;
                    unique case (i_in.req_type) inside
                        rrq_pkg::REQ_INSERT, rrq_pkg::REQ_REMOVE: begin
                            if (!in_id_ok) begin
                                n_status = rrq_pkg::ST_NOTFOUND;
                            end
                        end
                        rrq_pkg::REQ_POP: begin
                            if (r_count[in_q] == '0) begin
                                n_status = rrq_pkg::ST_EMPTY;
                            end
                        end
                        default: n_status = rrq_pkg::ST_OK;
                    endcase
                end
            end
            rrq_pkg::S_TAG_RD: begin
                tg_raddr = id_idx;
            end
            rrq_pkg::S_TAG_CHK: begin
                if (r_req == rrq_pkg::REQ_INSERT) begin
                    if (tag_cur == q_tag) begin
                        n_status = rrq_pkg::ST_DUP;
                    end else if (tag_cur != '0) begin
                        n_status = rrq_pkg::ST_OTHER;
                    end else begin
                        // new tail: clear its link and tag it
                        lk_we             = 1'b1;
                        lk_waddr          = id_idx;
                        lk_wdata          = '0;
                        tg_we             = 1'b1;
                        tg_waddr          = id_idx;
                        tg_wdata          = q_tag;
                        n_tag_vld[id_idx] = 1'b1;
                        if (r_count[r_q] == '0) begin
                            n_head[r_q]  = r_id;
                            n_tail[r_q]  = r_id;
                            n_count[r_q] = r_count[r_q] + CW'(1);
                        end
                    end
                end else if (tag_cur != q_tag || r_count[r_q] == '0) begin
                    n_status = rrq_pkg::ST_NOTFOUND;
                end else if (r_head[r_q] == r_id) begin
                    lk_raddr = id_idx;
                end else begin
                    // start the predecessor walk at the head
                    lk_raddr = IDX_W'(r_head[r_q]);
                    n_pre    = r_head[r_q];
                    n_steps  = '0;
                end
            end
            rrq_pkg::S_INS_LINK: begin
                lk_we        = 1'b1;
                lk_waddr     = IDX_W'(r_tail[r_q]);
                lk_wdata     = r_id;
                n_tail[r_q]  = r_id;
                n_count[r_q] = r_count[r_q] + CW'(1);
            end
            rrq_pkg::S_HEAD_RM: begin
                n_head[r_q]       = lk_rdata;
                n_tag_vld[id_idx] = 1'b0;
                n_count[r_q]      = r_count[r_q] - CW'(1);
                if (r_count[r_q] == CW'(1)) begin
                    n_head[r_q] = '0;
                    n_tail[r_q] = '0;
                end
            end
            rrq_pkg::S_WALK: begin
                // one link per cycle until the predecessor is found or the step limit runs out
                if (lk_rdata == r_id) begin
                    lk_raddr = id_idx;
                end else if (r_steps == IDX_W'(MAX_PROCS - 1)) begin
                    n_status = rrq_pkg::ST_NOTFOUND;
                end else begin
                    n_pre    = lk_rdata;
                    n_steps  = r_steps + IDX_W'(1);
                    lk_raddr = IDX_W'(lk_rdata);
                end
            end
            rrq_pkg::S_UNLINK: begin
                lk_we             = 1'b1;
                lk_waddr          = IDX_W'(r_pre);
                lk_wdata          = lk_rdata;
                n_tag_vld[id_idx] = 1'b0;
                n_count[r_q]      = r_count[r_q] - CW'(1);
                if (r_tail[r_q] == r_id) begin
                    n_tail[r_q] = r_pre;
                end
                if (r_count[r_q] == CW'(1)) begin
                    n_head[r_q] = '0;
                    n_tail[r_q] = '0;
                end
            end
            rrq_pkg::S_POP_RD: begin
                lk_raddr = IDX_W'(r_head[r_q]);
            end
            rrq_pkg::S_POP_WR: begin
                n_pop_id                         = r_head[r_q];
                n_head[r_q]                      = lk_rdata;
                n_tag_vld[IDX_W'(r_head[r_q])]   = 1'b0;
                n_count[r_q]                     = r_count[r_q] - CW'(1);
                if (r_count[r_q] == CW'(1)) begin
                    n_head[r_q] = '0;
                    n_tail[r_q] = '0;
                end
            end
            rrq_pkg::S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out.status = r_status;
                    n_out.out_id = r_pop_id;
                end
            end
            default: begin
                n_status = r_status;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_tag_vld   <= '0;
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_head[q]  <= '0;
                r_tail[q]  <= '0;
                r_count[q] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_tag_vld   <= n_tag_vld;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_q      <= n_q;
        r_id     <= n_id;
        r_pre    <= n_pre;
        r_steps  <= n_steps;
        r_status <= n_status;
        r_pop_id <= n_pop_id;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != rrq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // checks
    `RRQ_ASSERT_IMP(a_empty_settled, i_clk, i_rst_n, r_count[0] == '0,
        r_head[0] == '0 && r_tail[0] == '0, "empty queue has stale head or tail")
    `RRQ_ASSERT_IMP(a_out_from_done, i_clk, i_rst_n, r_out_valid && !$past(r_out_valid),
        $past(r_state) == rrq_pkg::S_DONE, "response loaded outside final state")
    `RRQ_ASSERT_IMP(a_id_only_on_ok, i_clk, i_rst_n,
        r_out_valid && r_out.status != rrq_pkg::ST_OK,
        r_out.out_id == '0, "nonzero id on a failed request")
    `RRQ_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, in_acc,
        r_state != rrq_pkg::S_IDLE, "sequencer idle after accepting a request")

endmodule

/* hw/rtl/rrq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on a same-address write
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sim/tb_round_robin_ready_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_round_robin_ready_queue
// Self-checking bench for the linked-list ready/wait queues. A clocked driver
// feeds request words from a pending queue. A clocked monitor checks each
// response word against a shadow copy of the queue lists, kept up to date as
// requests are accepted. A short directed list comes first. Random bursts
// follow, with small and full id pools and varied insert weight, run under
// three idle profiles plus one long output hold-off.
// ----------------------------------------------------------------------------
module tb_round_robin_ready_queue;

    localparam int MAX_P       = rrq_pkg::MAX_PROCS_DEF;
    localparam int ID_W        = rrq_pkg::ID_W;
    localparam int HOLD_CYCLES = 300;
    localparam int WDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES = MAX_P + 20;
    localparam int MAX_REPORTS = 10;

    // unused request code, answered ok with no effect
    localparam logic [rrq_pkg::REQ_W-1:0] REQ_RSVD = 2'd3;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    rrq_pkg::t_req_word i_in        = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    rrq_pkg::t_rsp_word o_out;
    logic               i_out_stall = 1'b0;

    round_robin_ready_queue u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

    // shadow copy of the queue lists
    bit [ID_W-1:0] sh_link  [MAX_P];
    bit [1:0]      sh_tag   [MAX_P];
    bit [ID_W-1:0] sh_head  [2];
    bit [ID_W-1:0] sh_tail  [2];
    bit [6:0]      sh_count [2];

    rrq_pkg::t_req_word req_pend_q[$];
    rrq_pkg::t_rsp_word rsp_expect_q[$];

    int snd_idle_pct = 12;
    int rcv_idle_pct = 63;
    int hold_req     = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int idle_cycles  = 0;
    int n_sent       = 0;
    int n_rcvd       = 0;
    int n_err        = 0;
    int max_qlen     = 0;
    int max_walk     = 0;
    int st_hits [8];

    // clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // reset, asserted at time zero and then released
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // empty queue gets head and tail back to zero
    function automatic void settle_queue(int q);
        if (sh_count[q] == 0) begin
            sh_head[q] = '0;
            sh_tail[q] = '0;
        end
    endfunction

    // expected response for one request, updating the shadow lists
    function automatic rrq_pkg::t_rsp_word predict_sched_rsp(rrq_pkg::t_req_word w);
        rrq_pkg::t_rsp_word r;
        int q;
        int id;
        int pre;
        int steps;
        int h;
        bit unlinked;
        r = '0;
        r.status = rrq_pkg::ST_OK;
        q = int'(w.queue_sel);
        id = int'(w.proc_id);
        unlinked = 1'b0;
        case (w.req_type)
            rrq_pkg::REQ_INSERT: begin
                if (int'(sh_tag[id]) == q + 1) begin
                    r.status = rrq_pkg::ST_DUP;
                end else if (sh_tag[id] != 0) begin
                    r.status = rrq_pkg::ST_OTHER;
                end else begin
                    sh_link[id] = '0;
                    if (sh_count[q] == 0) sh_head[q] = ID_W'(id);
                    else sh_link[sh_tail[q]] = ID_W'(id);
                    sh_tail[q] = ID_W'(id);
                    sh_count[q] = sh_count[q] + 7'd1;
                    sh_tag[id] = 2'(q + 1);
                    if (int'(sh_count[q]) > max_qlen) max_qlen = int'(sh_count[q]);
                end
            end
            rrq_pkg::REQ_REMOVE: begin
                if (int'(sh_tag[id]) != q + 1 || sh_count[q] == 0) begin
                    r.status = rrq_pkg::ST_NOTFOUND;
                end else if (int'(sh_head[q]) == id) begin
                    sh_head[q] = sh_link[id];
                    unlinked = 1'b1;
                end else begin
                    // walk from the head to find the predecessor
                    pre = int'(sh_head[q]);
                    steps = 0;
                    while (steps < MAX_P && int'(sh_link[pre]) != id) begin
                        pre = int'(sh_link[pre]);
                        steps++;
                    end
                    if (steps > max_walk) max_walk = steps;
                    if (steps == MAX_P) begin
                        r.status = rrq_pkg::ST_NOTFOUND;
                    end else begin
                        sh_link[pre] = sh_link[id];
                        if (int'(sh_tail[q]) == id) sh_tail[q] = ID_W'(pre);
                        unlinked = 1'b1;
                    end
                end
                if (unlinked) begin
                    sh_tag[id] = '0;
                    sh_count[q] = sh_count[q] - 7'd1;
                    settle_queue(q);
                end
            end
            rrq_pkg::REQ_POP: begin
                if (sh_count[q] == 0) begin
                    r.status = rrq_pkg::ST_EMPTY;
                end else begin
                    h = int'(sh_head[q]);
                    r.out_id = ID_W'(h);
                    sh_head[q] = sh_link[h];
                    sh_tag[h] = '0;
                    sh_count[q] = sh_count[q] - 7'd1;
                    settle_queue(q);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic rrq_pkg::t_req_word mk_req(logic [rrq_pkg::REQ_W-1:0] rt,
                                                  logic qs, int id);
        rrq_pkg::t_req_word w;
        w.req_type = rt;
        w.queue_sel = qs;
        w.proc_id = ID_W'(id);
        return w;
    endfunction

    task automatic note_error(string what, rrq_pkg::t_rsp_word exp_w,
                              rrq_pkg::t_rsp_word got_w);
        n_err++;
        if (n_err <= MAX_REPORTS) begin
            $display("%0t: %s: expected status %0d id %0d, got status %0d id %0d",
                     $realtime, what, exp_w.status, exp_w.out_id,
                     got_w.status, got_w.out_id);
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        logic took;
        took = i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (took) begin
                rsp_expect_q.push_back(predict_sched_rsp(i_in));
                n_sent++;
            end
            if (took || !i_in_valid) begin
                if (req_pend_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    i_in       <= req_pend_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and output stall
    always @(posedge i_clk) begin
        rrq_pkg::t_rsp_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_rcvd++;
            st_hits[o_out.status]++;
            if (rsp_expect_q.size() == 0) begin
                note_error("response with nothing outstanding", '0, o_out);
            end else begin
                want = rsp_expect_q.pop_front();
                if (o_out.status !== want.status || o_out.out_id !== want.out_id)
                    note_error("response mismatch", want, o_out);
            end
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (hold_seen != hold_req) begin
            // long hold-off so the block backs up into its input
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // cycles with work outstanding but no word moving
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else if (req_pend_q.size() != 0 || i_in_valid || rsp_expect_q.size() != 0)
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < WDOG_LIMIT) @(posedge i_clk);
        $display("%0t: watchdog, no progress for %0d cycles", $realtime, WDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    task automatic drain_all();
        while (req_pend_q.size() != 0 || i_in_valid || rsp_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // random bursts: small id pool for collisions, full pool for long lists
    task automatic queue_random_items(int n);
        int left;
        int burst;
        int pool;
        int ins_w;
        int r;
        rrq_pkg::t_req_word w;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(20, 60);
            pool  = ($urandom_range(3) == 0) ? MAX_P : 16;
            ins_w = $urandom_range(35, 65);
            for (int k = 0; k < burst && left > 0; k++) begin
                r = $urandom_range(99);
                w.queue_sel = 1'($urandom_range(1));
                w.proc_id = ID_W'($urandom_range(pool - 1));
                if (r < ins_w) w.req_type = rrq_pkg::REQ_INSERT;
                else if (r < ins_w + (100 - ins_w) / 2) w.req_type = rrq_pkg::REQ_REMOVE;
                else if (r < 97) w.req_type = rrq_pkg::REQ_POP;
                else w.req_type = REQ_RSVD;
                req_pend_q.push_back(w);
                left--;
            end
        end
    endtask

    // stimulus and end of run
    initial begin
        while (!i_rst_n) @(posedge i_clk);

        // directed: empty pops, duplicates, other-queue inserts, unlinks
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_POP,    1'b0, 0));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_POP,    1'b1, 63));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_REMOVE, 1'b0, 5));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_INSERT, 1'b0, 0));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_INSERT, 1'b0, 63));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_INSERT, 1'b0, 5));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_INSERT, 1'b0, 63));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_INSERT, 1'b1, 63));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_INSERT, 1'b1, 0));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_REMOVE, 1'b0, 63));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_REMOVE, 1'b0, 5));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_INSERT, 1'b0, 17));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_REMOVE, 1'b0, 0));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_POP,    1'b0, 0));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_POP,    1'b0, 0));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_INSERT, 1'b1, 42));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_INSERT, 1'b1, 1));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_REMOVE, 1'b0, 42));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_POP,    1'b1, 0));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_REMOVE, 1'b1, 1));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_REMOVE, 1'b1, 1));
        req_pend_q.push_back(mk_req(REQ_RSVD,            1'b1, 63));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_INSERT, 1'b0, 1));
        req_pend_q.push_back(mk_req(rrq_pkg::REQ_POP,    1'b0, 42));

        queue_random_items(700);
        drain_all();

        snd_idle_pct = 63;
        rcv_idle_pct = 12;
        queue_random_items(700);
        drain_all();

        // no idling, one long output hold-off at the start
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req <= hold_req + 1;
        queue_random_items(600);
        drain_all();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (rsp_expect_q.size() != 0) begin
            n_err++;
            $display("%0d responses never arrived", rsp_expect_q.size());
        end

        $display("Sent %0d requests, checked %0d responses, %0d errors",
                 n_sent, n_rcvd, n_err);
        $display("Status ok/dup/notfound/empty/other: %0d/%0d/%0d/%0d/%0d",
                 st_hits[rrq_pkg::ST_OK], st_hits[rrq_pkg::ST_DUP],
                 st_hits[rrq_pkg::ST_NOTFOUND], st_hits[rrq_pkg::ST_EMPTY],
                 st_hits[rrq_pkg::ST_OTHER]);
        $display("Longest list %0d, deepest walk %0d", max_qlen, max_walk);
        if (n_err == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
